// ===== design/gtms_pkg.sv =====
// gtms_pkg: shared types, widths and constants of the guide/target match scorer.
// Used by every module of the design folder; depends on nothing else.
package gtms_pkg;

	localparam int MAX_LEN_DEF = 32;
	localparam int CNT_W       = 7;
	localparam int TBL_DEPTH   = 32;
	localparam int TBL_AW      = 5;
	localparam int WGT_W       = 16;
	localparam int BASE_W      = 8;
	localparam int COST_W      = 24;
	localparam int FRAC_W      = 17;
	localparam int SCORE_W     = 17;
	localparam int PEN_W       = 18;
	localparam int BULGE_W     = 24;
	localparam int SUM_W       = 26;
	localparam int TOT_W       = 35;
	localparam int DIVR_W      = CNT_W + 1;
	localparam int QDEPTH      = 2;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 17;
	localparam int WU_W        = 6;

	localparam logic [COST_W-1:0]  COST_MAX  = '1;
	localparam logic [WGT_W-1:0]   ONE_Q8    = 16'd256;
	localparam logic [TOT_W-1:0]   Q_LIMIT   = 35'd98304;
	localparam logic [BASE_W-1:0]  BASE_GC_C = 8'd1;
	localparam logic [BASE_W-1:0]  BASE_GC_G = 8'd2;

	localparam logic [FRAC_W-1:0]  GC_LOW_RST  = 17'd26214;
	localparam logic [FRAC_W-1:0]  GC_HIGH_RST = 17'd52429;
	localparam logic [WGT_W-1:0]   BULGE_RST   = 16'd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GC_LOW       = 3'd0,
		REG_GC_HIGH      = 3'd1,
		REG_BULGE_COST   = 3'd2,
		REG_SCORE_FLOOR  = 3'd3,
		REG_WEIGHTS_USED = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [FRAC_W-1:0]         gc_low;
		logic [FRAC_W-1:0]         gc_high;
		logic [WGT_W-1:0]          bulge_cost;
		logic signed [SCORE_W-1:0] score_floor;
		logic [WU_W-1:0]           weights_used;
	} cfg_t;

	typedef struct packed {
		logic [COST_W-1:0] cost;
		logic [CNT_W-1:0]  guide_cnt;
		logic [CNT_W-1:0]  window_cnt;
		logic [CNT_W-1:0]  gc_cnt;
		logic              overflow;
		logic [WGT_W-1:0]  pam;
	} job_t;

endpackage

// ===== design/gtms_queue.sv =====
// gtms_queue: small FIFO of finished pair jobs between front and back.
// Depends on gtms_pkg (job_t, QDEPTH).
module gtms_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  gtms_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output gtms_pkg::job_t pop_job
);

	localparam int PTR_W = (gtms_pkg::QDEPTH > 1) ? $clog2(gtms_pkg::QDEPTH) : 1;
	localparam int CNT_QW = $clog2(gtms_pkg::QDEPTH + 1);

	gtms_pkg::job_t entry_q [gtms_pkg::QDEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_QW-1:0] count_q;

	assign full    = (count_q == CNT_QW'(gtms_pkg::QDEPTH));
	assign empty   = (count_q == '0);
	assign pop_job = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(gtms_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(gtms_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if ((push && !full) && !(pop && !empty)) begin
				count_q <= count_q + 1'b1;
			end else if (!(push && !full) && (pop && !empty)) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/gtms_front.sv =====
// gtms_front: accepts items, keeps the weight table and the per-pair accumulators,
// and pushes one job per pair at the last position. Depends on gtms_pkg.
module gtms_front #(
	parameter int MAX_LEN = gtms_pkg::MAX_LEN_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic                           cmd,
	input  logic [gtms_pkg::BASE_W-1:0]    guide_base,
	input  logic [gtms_pkg::BASE_W-1:0]    window_base,
	input  logic                           has_guide,
	input  logic                           has_window,
	input  logic                           last,
	input  logic [gtms_pkg::WGT_W-1:0]     pam_cost,
	input  logic [gtms_pkg::TBL_AW-1:0]    weight_index,
	input  logic [gtms_pkg::WGT_W-1:0]     weight_value,
	input  logic [gtms_pkg::WU_W-1:0]      weights_used,
	output logic                           push,
	output gtms_pkg::job_t                 push_job
);

	localparam int PW = $clog2(MAX_LEN + 1);

	logic [gtms_pkg::WGT_W-1:0] weight_table [gtms_pkg::TBL_DEPTH];

	logic [PW-1:0]               pos_q;
	logic [gtms_pkg::COST_W-1:0] cost_q;
	logic [PW-1:0]               guide_cnt_q;
	logic [PW-1:0]               window_cnt_q;
	logic [PW-1:0]               gc_cnt_q;
	logic                        ovf_q;
	logic [gtms_pkg::WGT_W-1:0]  wt_rd_q;

	logic                        accept;
	logic                        score_item;
	logic                        in_range;
	logic                        use_table;
	logic                        mismatch;
	logic [gtms_pkg::WGT_W-1:0]  weight;
	logic [gtms_pkg::COST_W:0]   cost_sum;
	logic [gtms_pkg::COST_W-1:0] cost_nxt;
	logic [PW-1:0]               pos_nxt;
	logic [PW-1:0]               guide_nxt;
	logic [PW-1:0]               window_nxt;
	logic [PW-1:0]               gc_nxt;
	logic                        ovf_nxt;
	logic [PW-1:0]               rd_pos;
	logic [gtms_pkg::TBL_AW-1:0] rd_addr;

	assign accept     = in_valid && !in_stall;
	assign score_item = accept && !cmd;
	assign in_range   = (pos_q < PW'(MAX_LEN));
	assign use_table  = (gtms_pkg::CNT_W'(pos_q) < gtms_pkg::CNT_W'(weights_used))
		&& (gtms_pkg::CNT_W'(pos_q) < gtms_pkg::CNT_W'(gtms_pkg::TBL_DEPTH));
	assign weight     = use_table ? wt_rd_q : gtms_pkg::ONE_Q8;
	assign mismatch   = has_guide && has_window && (guide_base != window_base);
	assign cost_sum   = {1'b0, cost_q} + (gtms_pkg::COST_W + 1)'(weight);

	always_comb begin
		pos_nxt    = pos_q;
		cost_nxt   = cost_q;
		guide_nxt  = guide_cnt_q;
		window_nxt = window_cnt_q;
		gc_nxt     = gc_cnt_q;
		ovf_nxt    = ovf_q;
		if (!in_range) begin
			ovf_nxt = 1'b1;
		end else begin
			pos_nxt = pos_q + 1'b1;
			if (mismatch) begin
				cost_nxt = cost_sum[gtms_pkg::COST_W] ? gtms_pkg::COST_MAX
					: cost_sum[gtms_pkg::COST_W-1:0];
			end
			if (has_guide) begin
				guide_nxt = guide_cnt_q + 1'b1;
			end
			if (has_window) begin
				window_nxt = window_cnt_q + 1'b1;
				if (window_base == gtms_pkg::BASE_GC_C || window_base == gtms_pkg::BASE_GC_G) begin
					gc_nxt = gc_cnt_q + 1'b1;
				end
			end
		end
	end

	assign push                = score_item && last;
	assign push_job.cost       = cost_nxt;
	assign push_job.guide_cnt  = gtms_pkg::CNT_W'(guide_nxt);
	assign push_job.window_cnt = gtms_pkg::CNT_W'(window_nxt);
	assign push_job.gc_cnt     = gtms_pkg::CNT_W'(gc_nxt);
	assign push_job.overflow   = ovf_nxt;
	assign push_job.pam        = pam_cost;

	// prefetch the entry for the position that follows this edge
	assign rd_pos  = push ? '0 : (score_item ? pos_nxt : pos_q);
	assign rd_addr = gtms_pkg::TBL_AW'(rd_pos);

	always_ff @(posedge clk) begin
		if (accept && cmd) begin
			weight_table[weight_index] <= weight_value;
		end
		wt_rd_q <= (accept && cmd && (weight_index == rd_addr)) ? weight_value
			: weight_table[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			cost_q       <= '0;
			guide_cnt_q  <= '0;
			window_cnt_q <= '0;
			gc_cnt_q     <= '0;
			ovf_q        <= 1'b0;
		end else if (score_item) begin
			if (last) begin
				pos_q        <= '0;
				cost_q       <= '0;
				guide_cnt_q  <= '0;
				window_cnt_q <= '0;
				gc_cnt_q     <= '0;
				ovf_q        <= 1'b0;
			end else begin
				pos_q        <= pos_nxt;
				cost_q       <= cost_nxt;
				guide_cnt_q  <= guide_nxt;
				window_cnt_q <= window_nxt;
				gc_cnt_q     <= gc_nxt;
				ovf_q        <= ovf_nxt;
			end
		end
	end

endmodule

// ===== design/gtms_div.sv =====
// gtms_div: restoring divider, one quotient bit per cycle, shared by both
// divisions of a pair. Depends on gtms_pkg (TOT_W, DIVR_W).
module gtms_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [gtms_pkg::TOT_W-1:0]    dividend,
	input  logic [gtms_pkg::DIVR_W-1:0]   divisor,
	output logic                          done,
	output logic [gtms_pkg::TOT_W-1:0]    quotient
);

	localparam int CW = $clog2(gtms_pkg::TOT_W + 1);

	logic [gtms_pkg::DIVR_W-1:0] divisor_q;
	logic [gtms_pkg::DIVR_W-1:0] rem_q;
	logic [gtms_pkg::TOT_W-1:0]  quo_q;
	logic [CW-1:0]               cnt_q;
	logic                        busy_q;
	logic                        done_q;

	logic [gtms_pkg::DIVR_W:0]   trial;
	logic                        take;

	assign trial    = {rem_q, quo_q[gtms_pkg::TOT_W-1]};
	assign take     = (trial >= {1'b0, divisor_q});
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			divisor_q <= divisor;
			rem_q     <= '0;
			quo_q     <= dividend;
		end else if (busy_q) begin
			rem_q <= take ? gtms_pkg::DIVR_W'(trial - {1'b0, divisor_q})
				: trial[gtms_pkg::DIVR_W-1:0];
			quo_q <= {quo_q[gtms_pkg::TOT_W-2:0], take};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CW'(gtms_pkg::TOT_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== design/gtms_back.sv =====
// gtms_back: takes pair jobs from the queue, forms bulge, GC and total cost,
// divides on gtms_div and drives the output register. Depends on gtms_pkg, gtms_div.
module gtms_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  gtms_pkg::cfg_t                       cfg,
	input  logic                                 empty,
	input  gtms_pkg::job_t                       pop_job,
	output logic                                 pop,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [gtms_pkg::SCORE_W-1:0]  score,
	output logic                                 length_error
);

	localparam logic signed [gtms_pkg::SCORE_W:0] ONE_Q15_EXT = 18'sd32768;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_BULGE  = 8'b0000_0010,
		ST_DIV_GC = 8'b0000_0100,
		ST_GC_PEN = 8'b0000_1000,
		ST_SUM    = 8'b0001_0000,
		ST_Q_GO   = 8'b0010_0000,
		ST_DIV_Q  = 8'b0100_0000,
		ST_FIN    = 8'b1000_0000
	} back_state_t;

	back_state_t                 state_q;
	gtms_pkg::job_t              job_q;
	logic [gtms_pkg::BULGE_W-1:0] bulge_q;
	logic [gtms_pkg::FRAC_W-1:0] frac_q;
	logic [gtms_pkg::PEN_W-1:0]  pen_q;
	logic [gtms_pkg::TOT_W-1:0]  total_q;
	logic [gtms_pkg::TOT_W-1:0]  quo_q;
	logic                        out_valid_q;
	logic signed [gtms_pkg::SCORE_W-1:0] score_q;
	logic                        len_err_q;

	logic                        div_start;
	logic [gtms_pkg::TOT_W-1:0]  div_dividend;
	logic [gtms_pkg::DIVR_W-1:0] div_divisor;
	logic                        div_done;
	logic [gtms_pkg::TOT_W-1:0]  div_quotient;

	logic [gtms_pkg::CNT_W-1:0]  diff;
	logic [gtms_pkg::BULGE_W-1:0] bulge_once;
	logic [gtms_pkg::BULGE_W-1:0] bulge_prod;
	logic [gtms_pkg::CNT_W-1:0]  span;
	logic [gtms_pkg::DIVR_W-1:0] span2;
	logic [gtms_pkg::FRAC_W:0]   dist_lo;
	logic [gtms_pkg::FRAC_W:0]   dist_hi;
	logic [gtms_pkg::FRAC_W:0]   gc_gap;
	logic [gtms_pkg::SUM_W-1:0]  base_sum;
	logic signed [gtms_pkg::SCORE_W:0] raw_score;
	logic signed [gtms_pkg::SCORE_W:0] floor_ext;
	logic signed [gtms_pkg::SCORE_W-1:0] final_score;
	logic                        out_free;

	assign pop      = (state_q == ST_IDLE) && !empty;
	assign out_free = !out_valid_q || !out_stall;

	assign diff = (job_q.window_cnt > job_q.guide_cnt) ? job_q.window_cnt - job_q.guide_cnt
		: job_q.guide_cnt - job_q.window_cnt;
	assign bulge_once = gtms_pkg::BULGE_W'(diff) * gtms_pkg::BULGE_W'(cfg.bulge_cost);
	assign bulge_prod = (job_q.window_cnt > job_q.guide_cnt)
		? {bulge_once[gtms_pkg::BULGE_W-2:0], 1'b0} : bulge_once;

	assign span  = (job_q.guide_cnt > gtms_pkg::CNT_W'(1)) ? job_q.guide_cnt
		: gtms_pkg::CNT_W'(1);
	assign span2 = {span, 1'b0};

	assign div_start    = ((state_q == ST_BULGE) && (job_q.window_cnt != '0))
		|| (state_q == ST_Q_GO);
	assign div_dividend = (state_q == ST_BULGE)
		? gtms_pkg::TOT_W'({job_q.gc_cnt, 16'h0000}) : total_q;
	assign div_divisor  = (state_q == ST_BULGE)
		? gtms_pkg::DIVR_W'(job_q.window_cnt) : span2;

	assign dist_lo = (frac_q >= cfg.gc_low) ? {1'b0, frac_q - cfg.gc_low}
		: {1'b0, cfg.gc_low - frac_q};
	assign dist_hi = (frac_q >= cfg.gc_high) ? {1'b0, frac_q - cfg.gc_high}
		: {1'b0, cfg.gc_high - frac_q};
	assign gc_gap  = (dist_lo < dist_hi) ? dist_lo : dist_hi;

	assign base_sum = gtms_pkg::SUM_W'(job_q.cost) + gtms_pkg::SUM_W'(bulge_q)
		+ gtms_pkg::SUM_W'(job_q.pam);

	assign raw_score = ONE_Q15_EXT - $signed({1'b0, quo_q[gtms_pkg::SCORE_W-1:0]});
	assign floor_ext = (gtms_pkg::SCORE_W + 1)'(cfg.score_floor);

	always_comb begin
		if ((quo_q > gtms_pkg::Q_LIMIT) || (raw_score < floor_ext)) begin
			final_score = (floor_ext > ONE_Q15_EXT) ? ONE_Q15_EXT[gtms_pkg::SCORE_W-1:0]
				: cfg.score_floor;
		end else begin
			final_score = raw_score[gtms_pkg::SCORE_W-1:0];
		end
	end

	gtms_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= pop_job;
		end
		if (state_q == ST_BULGE) begin
			bulge_q <= bulge_prod;
			pen_q   <= '0;
		end
		if ((state_q == ST_DIV_GC) && div_done) begin
			frac_q <= div_quotient[gtms_pkg::FRAC_W-1:0];
		end
		if (state_q == ST_GC_PEN) begin
			pen_q <= ((frac_q >= cfg.gc_low) && (frac_q <= cfg.gc_high)) ? '0
				: gtms_pkg::PEN_W'({gc_gap, 1'b0});
		end
		if (state_q == ST_SUM) begin
			total_q <= gtms_pkg::TOT_W'({base_sum, 8'h00}) + gtms_pkg::TOT_W'(pen_q);
		end
		if ((state_q == ST_DIV_Q) && div_done) begin
			quo_q <= div_quotient;
		end
		if ((state_q == ST_FIN) && out_free) begin
			score_q   <= final_score;
			len_err_q <= job_q.overflow;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						state_q <= ST_BULGE;
					end
				end
				ST_BULGE: begin
					state_q <= (job_q.window_cnt != '0) ? ST_DIV_GC : ST_SUM;
				end
				ST_DIV_GC: begin
					if (div_done) begin
						state_q <= ST_GC_PEN;
					end
				end
				ST_GC_PEN: state_q <= ST_SUM;
				ST_SUM:    state_q <= ST_Q_GO;
				ST_Q_GO:   state_q <= ST_DIV_Q;
				ST_DIV_Q: begin
					if (div_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign score        = score_q;
	assign length_error = len_err_q;

endmodule

// ===== design/guide_target_match_scorer.sv =====
// guide_target_match_scorer: top level; config registers, front, job queue and back.
// Positions: one item per cycle; in_stall rises only while the two-entry job queue is full.
// Pair: out_valid rises once the back end has run two passes of the one-bit-per-cycle divider
// (one pass with no window bases); the back end takes a new pair only once it has issued the last.
// Reset (arst_n, async, low): accumulators, queue and control clear; config takes its
// reset values; weight table is not cleared.
module guide_target_match_scorer #(
	parameter int MAX_LEN = gtms_pkg::MAX_LEN_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                cmd,
	input  logic [gtms_pkg::BASE_W-1:0]         guide_base,
	input  logic [gtms_pkg::BASE_W-1:0]         window_base,
	input  logic                                has_guide,
	input  logic                                has_window,
	input  logic                                last,
	input  logic [gtms_pkg::WGT_W-1:0]          pam_cost,
	input  logic [gtms_pkg::TBL_AW-1:0]         weight_index,
	input  logic [gtms_pkg::WGT_W-1:0]          weight_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [gtms_pkg::SCORE_W-1:0] score,
	output logic                                length_error,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gtms_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gtms_pkg::CFG_DATA_W-1:0]     cfg_data
);

	gtms_pkg::cfg_t cfg_q;
	gtms_pkg::job_t push_job;
	gtms_pkg::job_t pop_job;
	logic           push;
	logic           pop;
	logic           full;
	logic           empty;

	assign cfg_ready = 1'b1;
	assign in_stall  = full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gc_low       <= gtms_pkg::GC_LOW_RST;
			cfg_q.gc_high      <= gtms_pkg::GC_HIGH_RST;
			cfg_q.bulge_cost   <= gtms_pkg::BULGE_RST;
			cfg_q.score_floor  <= '0;
			cfg_q.weights_used <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				gtms_pkg::REG_GC_LOW:       cfg_q.gc_low <= cfg_data;
				gtms_pkg::REG_GC_HIGH:      cfg_q.gc_high <= cfg_data;
				gtms_pkg::REG_BULGE_COST:   cfg_q.bulge_cost <= cfg_data[gtms_pkg::WGT_W-1:0];
				gtms_pkg::REG_SCORE_FLOOR:  cfg_q.score_floor <= $signed(cfg_data);
				gtms_pkg::REG_WEIGHTS_USED: cfg_q.weights_used <= cfg_data[gtms_pkg::WU_W-1:0];
				default: ;
			endcase
		end
	end

	gtms_front #(
		.MAX_LEN (MAX_LEN)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.guide_base   (guide_base),
		.window_base  (window_base),
		.has_guide    (has_guide),
		.has_window   (has_window),
		.last         (last),
		.pam_cost     (pam_cost),
		.weight_index (weight_index),
		.weight_value (weight_value),
		.weights_used (cfg_q.weights_used),
		.push         (push),
		.push_job     (push_job)
	);

	gtms_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.pop_job  (pop_job)
	);

	gtms_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.empty        (empty),
		.pop_job      (pop_job),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.score        (score),
		.length_error (length_error)
	);

endmodule
